// ===== design/gbfs_pkg.sv =====
`default_nettype none
package gbfs_pkg;
   localparam int SheetBytes = 4096;
   localparam int MaxBox     = 16;
   localparam int ScreenW    = 320;
   localparam int ScreenH    = 240;

   localparam logic [2:0] RegInvScale   = 3'd0;
   localparam logic [2:0] RegSheetTiles = 3'd1;
   localparam logic [2:0] RegCellHeight = 3'd2;
   localparam logic [2:0] RegClipLeft   = 3'd3;
   localparam logic [2:0] RegClipRight  = 3'd4;

   localparam logic CmdWrite  = 1'b0;
   localparam logic CmdSample = 1'b1;

   // classified item handed from front to back
   typedef struct packed {
      logic        is_sample;
      logic [11:0] byte_addr;
      logic [7:0]  byte_data;
      logic [9:0]  glyph_x;
      logic [9:0]  glyph_y;
      logic [19:0] sx0;
      logic [19:0] sx1;
      logic [19:0] sy0;
      logic [19:0] sy1;
      logic [8:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic        visible;
   } job_type;

   // morton interleave of an 8x8 tile coordinate
   function automatic logic [5:0] morton(input logic [2:0] tx, input logic [2:0] ty);
      morton = {ty[2], tx[2], ty[1], tx[1], ty[0], tx[0]};
   endfunction
endpackage
`default_nettype wire

// ===== design/gbfs_ram.sv =====
`default_nettype none
module gbfs_ram #(
   parameter int Width = 8,
   parameter int Depth = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]              rd_data
);
   logic [Width-1:0] mem [Depth];

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/gbfs_front.sv =====
`default_nettype none
module gbfs_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic                 cmd,
   input  wire logic [11:0]          byte_addr,
   input  wire logic [7:0]           byte_data,
   input  wire logic [9:0]           glyph_x,
   input  wire logic [9:0]           glyph_y,
   input  wire logic [7:0]           glyph_width,
   input  wire logic signed [10:0]   dest_x,
   input  wire logic signed [10:0]   dest_y,
   input  wire logic [7:0]           offset_x,
   input  wire logic [7:0]           offset_y,
   input  wire logic [15:0]          inv_scale,
   input  wire logic [7:0]           cell_height,
   input  wire logic [8:0]           clip_left,
   input  wire logic [8:0]           clip_right,
   output logic                      job_valid,
   input  wire logic                 job_ready,
   output gbfs_pkg::job_type         job
);
   // stage 1: products
   logic        s1_v_ff;
   logic        s1_cmd_ff;
   logic [11:0] ba_ff;
   logic [7:0]  bd_ff;
   logic [23:0] p0x_ff, p1x_ff, p0y_ff, p1y_ff;
   logic [9:0]  gx_ff, gy_ff;
   logic [7:0]  gw_ff;
   logic signed [11:0] px_ff, py_ff;
   logic        s1_go;
   gbfs_pkg::job_type job_ff, job_in;
   logic        job_v_ff;

   assign s1_go    = s1_v_ff && (!job_v_ff || job_ready);
   assign in_ready = !s1_v_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (in_ready) s1_v_ff <= in_valid;
      if (in_ready && in_valid) begin
         s1_cmd_ff <= cmd;
         ba_ff <= byte_addr;
         bd_ff <= byte_data;
         p0x_ff <= 24'({8'd0, offset_x} * inv_scale);
         p1x_ff <= 24'({8'd0, offset_x} * inv_scale) + 24'(inv_scale);
         p0y_ff <= 24'({8'd0, offset_y} * inv_scale);
         p1y_ff <= 24'({8'd0, offset_y} * inv_scale) + 24'(inv_scale);
         gx_ff <= glyph_x;
         gy_ff <= glyph_y;
         gw_ff <= glyph_width;
         px_ff <= 12'(dest_x) + 12'(signed'({1'b0, offset_x}));
         py_ff <= 12'(dest_y) + 12'(signed'({1'b0, offset_y}));
      end
   end

   // box clamp as in one axis
   function automatic logic [19:0] box_end(input logic [11:0] s0, input logic [11:0] s1r,
                                          input logic [7:0] bound);
      logic [19:0] e;
      e = {8'd0, s1r};
      if (e <= {8'd0, s0}) e = {8'd0, s0} + 20'd1;
      if (e > {12'd0, bound}) e = {12'd0, bound};
      if (e > {8'd0, s0} && e - {8'd0, s0} > 20'(gbfs_pkg::MaxBox))
         e = {8'd0, s0} + 20'(gbfs_pkg::MaxBox);
      box_end = e;
   endfunction

   // stage 2: classify
   always_comb begin
      job_in = '0;
      job_in.is_sample = s1_cmd_ff == gbfs_pkg::CmdSample;
      job_in.byte_addr = ba_ff;
      job_in.byte_data = bd_ff;
      job_in.glyph_x = gx_ff;
      job_in.glyph_y = gy_ff;
      job_in.sx0 = {8'd0, p0x_ff[23:12]};
      job_in.sy0 = {8'd0, p0y_ff[23:12]};
      job_in.sx1 = box_end(p0x_ff[23:12], p1x_ff[23:12], gw_ff);
      job_in.sy1 = box_end(p0y_ff[23:12], p1y_ff[23:12], cell_height);
      job_in.pixel_x = px_ff[8:0];
      job_in.pixel_y = py_ff[7:0];
      job_in.visible = !px_ff[11] && !py_ff[11]
         && px_ff < 12'(gbfs_pkg::ScreenW) && py_ff < 12'(gbfs_pkg::ScreenH)
         && px_ff >= signed'({3'd0, clip_left}) && px_ff < signed'({3'd0, clip_right});
   end

   always_ff @(posedge clock) begin
      if (reset) job_v_ff <= 1'b0;
      else if (!job_v_ff || job_ready) job_v_ff <= s1_v_ff;
      if (s1_go) job_ff <= job_in;
   end

   assign job_valid = job_v_ff;
   assign job       = job_ff;
endmodule
`default_nettype wire

// ===== design/gbfs_back.sv =====
`default_nettype none
module gbfs_back #(
   parameter int SheetBytes = gbfs_pkg::SheetBytes
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      job_valid,
   output logic                           job_ready,
   input  wire gbfs_pkg::job_type         job,
   input  wire logic [6:0]                sheet_tiles,
   output logic                           wr_en,
   output logic [$clog2(SheetBytes)-1:0]  wr_addr,
   output logic [7:0]                     wr_data,
   output logic [$clog2(SheetBytes)-1:0]  rd_addr,
   input  wire logic [7:0]                rd_data,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output logic [7:0]                     alpha,
   output logic [8:0]                     pixel_x,
   output logic [7:0]                     pixel_y,
   output logic                           draw
);
   localparam int AW = $clog2(SheetBytes);
   typedef enum logic [4:0] {
      StIdle = 5'b00001, StRead = 5'b00010, StDiv = 5'b00100,
      StOut = 5'b01000, StWait = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   gbfs_pkg::job_type j_ff;
   logic [19:0] sx_ff, sy_ff;
   logic        pend_ff, nib_ff;
   logic [13:0] sum_ff;
   logic [12:0] cnt_ff;
   logic [17:0] num_ff;
   logic [4:0]  dcnt_ff;
   logic [18:0] rem_ff;
   logic        o_v_ff;
   logic [7:0]  o_a_ff;
   logic [8:0]  o_x_ff;
   logic [7:0]  o_y_ff;
   logic        o_d_ff;
   logic [20:0] col, row;
   logic [31:0] idx;
   logic        last;
   logic [3:0]  tex;
   logic [18:0] trial;

   // texel address of the current box position
   always_comb begin
      col = {11'd0, j_ff.glyph_x} + {1'b0, sx_ff};
      row = {11'd0, j_ff.glyph_y} + {1'b0, sy_ff};
      idx = (32'(row[20:3]) * 32'(sheet_tiles) + 32'(col[20:3])) * 32'd64
          + 32'(gbfs_pkg::morton(col[2:0], row[2:0]));
      rd_addr = idx[AW:1];
      last = (sx_ff + 20'd1 >= j_ff.sx1) && (sy_ff + 20'd1 >= j_ff.sy1);
      tex = nib_ff ? rd_data[7:4] : rd_data[3:0];
      trial = {rem_ff[17:0], num_ff[17]} - {6'd0, cnt_ff};
   end

   // sheet byte write, in item order
   assign wr_en   = state_ff == StRead && !j_ff.is_sample
                    && 32'(j_ff.byte_addr) < SheetBytes;
   assign wr_addr = AW'(j_ff.byte_addr);
   assign wr_data = j_ff.byte_data;

   assign job_ready = state_ff == StIdle;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle: if (job_valid) state_in = StRead;
         StRead: if (!j_ff.is_sample || j_ff.sx1 <= j_ff.sx0 || j_ff.sy1 <= j_ff.sy0)
                    state_in = StOut;
                 else if (last) state_in = StWait;
         StWait: state_in = StDiv;
         StDiv:  if (dcnt_ff == 5'd17) state_in = StOut;
         StOut:  if (!o_v_ff || out_ready) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         pend_ff  <= 1'b0;
         o_v_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= state_ff == StRead && state_in != StOut;
         if (o_v_ff && out_ready) o_v_ff <= 1'b0;
         if (state_ff == StOut && (!o_v_ff || out_ready)) o_v_ff <= 1'b1;
      end
      // accumulate texel arriving from memory
      if (pend_ff) begin
         sum_ff <= sum_ff + 14'(tex);
         cnt_ff <= cnt_ff + 13'd1;
      end
      nib_ff <= idx[0];
      case (state_ff)
         StIdle: begin
            j_ff <= job; sx_ff <= job.sx0; sy_ff <= job.sy0;
            sum_ff <= '0; cnt_ff <= '0;
         end
         StRead: begin
            if (sx_ff + 20'd1 >= j_ff.sx1) begin
               sx_ff <= j_ff.sx0; sy_ff <= sy_ff + 20'd1;
            end else sx_ff <= sx_ff + 20'd1;
         end
         StWait: begin
            // last texel arrives this cycle
            num_ff <= 18'(sum_ff + 14'(tex)) * 18'd17;
            rem_ff <= '0; dcnt_ff <= '0;
         end
         StDiv: begin
            // restoring divide, one quotient bit a cycle
            if (dcnt_ff < 5'd18) begin
               if (!trial[18]) rem_ff <= trial;
               else rem_ff <= {rem_ff[17:0], num_ff[17]};
               num_ff <= {num_ff[16:0], ~trial[18]};
               dcnt_ff <= dcnt_ff + 5'd1;
            end
         end
         StOut: if (!o_v_ff || out_ready) begin
            if (!j_ff.is_sample) begin
               o_a_ff <= '0; o_x_ff <= '0; o_y_ff <= '0; o_d_ff <= 1'b0;
            end else begin
               o_a_ff <= (cnt_ff == 0) ? 8'd0 : num_ff[7:0];
               o_x_ff <= j_ff.pixel_x; o_y_ff <= j_ff.pixel_y;
               o_d_ff <= j_ff.visible && cnt_ff != 0 && num_ff[7:0] != 8'd0;
            end
         end
         default: ;
      endcase
   end

   assign out_valid = o_v_ff;
   assign alpha = o_a_ff;
   assign pixel_x = o_x_ff;
   assign pixel_y = o_y_ff;
   assign draw = o_d_ff;

   // checks
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      o_v_ff && !out_ready |=> o_v_ff && $stable(o_a_ff)) else $error("result lost");
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      state_ff != StIdle |-> !job_ready) else $error("job taken while busy");
   a_draw_alpha: assert property (@(posedge clock) disable iff (reset)
      o_v_ff && o_d_ff |-> o_a_ff != 8'd0) else $error("draw with zero alpha");
endmodule
`default_nettype wire

// ===== design/glyph_box_filter_sampler_core.sv =====
`default_nettype none
// channel  | ports                 | moves
// req      | req_valid/req_ready   | write or sample item
// rsp      | rsp_valid/rsp_ready   | one result per item
// csr      | csr_we/csr_index/data | register write
// a write shows rsp_valid after the front stages and the back's read and out
// states; a sample adds one sheet memory read per box texel, a wait state and
// a bit-serial divide by the count; the back takes a new job only when idle
// two front stages feed the back through a one-entry job register
// reset is synchronous; the sheet store is not cleared
// either channel may stall freely without losing items
module glyph_box_filter_sampler_core #(
   parameter int SheetBytes = gbfs_pkg::SheetBytes
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_cmd,
   input  wire logic [11:0]          req_byte_addr,
   input  wire logic [7:0]           req_byte_data,
   input  wire logic [9:0]           req_glyph_x,
   input  wire logic [9:0]           req_glyph_y,
   input  wire logic [7:0]           req_glyph_width,
   input  wire logic signed [10:0]   req_dest_x,
   input  wire logic signed [10:0]   req_dest_y,
   input  wire logic [7:0]           req_offset_x,
   input  wire logic [7:0]           req_offset_y,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [7:0]                rsp_alpha,
   output logic [8:0]                rsp_pixel_x,
   output logic [7:0]                rsp_pixel_y,
   output logic                      rsp_draw,
   input  wire logic                 csr_we,
   input  wire logic [2:0]           csr_index,
   input  wire logic [15:0]          csr_data
);
   localparam int AW = $clog2(SheetBytes);
   logic [15:0] inv_ff;
   logic [6:0]  tiles_ff;
   logic [7:0]  ch_ff;
   logic [8:0]  cl_ff, cr_ff;
   logic        job_valid, job_ready, wr_en;
   gbfs_pkg::job_type job;
   logic [AW-1:0] wr_addr;
   logic [7:0]  wr_data;
   logic [AW-1:0] rd_addr;
   logic [7:0]  rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_ff <= 16'd4096; tiles_ff <= 7'd16; ch_ff <= 8'd30;
         cl_ff <= 9'd0; cr_ff <= 9'd320;
      end else if (csr_we) begin
         case (csr_index)
            gbfs_pkg::RegInvScale:   inv_ff <= csr_data;
            gbfs_pkg::RegSheetTiles: tiles_ff <= csr_data[6:0];
            gbfs_pkg::RegCellHeight: ch_ff <= csr_data[7:0];
            gbfs_pkg::RegClipLeft:   cl_ff <= csr_data[8:0];
            gbfs_pkg::RegClipRight:  cr_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // sheet store, written by the back in item order
   gbfs_ram #(.Width(8), .Depth(SheetBytes)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   gbfs_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_ready(req_ready),
      .cmd(req_cmd), .byte_addr(req_byte_addr), .byte_data(req_byte_data),
      .glyph_x(req_glyph_x), .glyph_y(req_glyph_y),
      .glyph_width(req_glyph_width), .dest_x(req_dest_x), .dest_y(req_dest_y),
      .offset_x(req_offset_x), .offset_y(req_offset_y), .inv_scale(inv_ff),
      .cell_height(ch_ff), .clip_left(cl_ff), .clip_right(cr_ff),
      .job_valid(job_valid), .job_ready(job_ready), .job(job));

   gbfs_back #(.SheetBytes(SheetBytes)) u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job_ready(job_ready),
      .job(job), .sheet_tiles(tiles_ff), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data(wr_data), .rd_addr(rd_addr), .rd_data(rd_data),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .alpha(rsp_alpha),
      .pixel_x(rsp_pixel_x), .pixel_y(rsp_pixel_y), .draw(rsp_draw));
endmodule
`default_nettype wire
